// ----- hdl/rgb_pixel_fade_scaler_macros.svh -----
// ----------------------------------------------------------------------------
// RGB pixel fade scaler assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RGB_PIXEL_FADE_SCALER_MACROS_SVH
`define RGB_PIXEL_FADE_SCALER_MACROS_SVH

`ifndef SYNTHESIS
`define RPFS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed.");
`define RPFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");
`else
`define RPFS_ASSERT_SAME(label, clk, rst, ante, cons)
`define RPFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/rpfs_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB pixel fade scaler package
// Shared constants, register indexes and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfs_pkg;

   localparam int FADE_STEPS = 64;
   localparam int STEP_W     = 6;
   localparam int FACTOR_W   = $clog2(FADE_STEPS + 1);
   localparam int PIXEL_W    = 32;
   localparam int CHAN_W     = 8;
   localparam int OFFSET_W   = 5;
   localparam int LENGTH_W   = 4;
   localparam int BPP_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;
   localparam int REQ_DATA_W  = 40;

   localparam logic [PIXEL_W-1:0] MASK_16 = 32'h0000_ffff;
   localparam logic [PIXEL_W-1:0] MASK_24 = 32'h00ff_ffff;
   localparam logic [PIXEL_W-1:0] MASK_32 = 32'hffff_ffff;

   localparam logic [BPP_W-1:0] BPP_2 = 3'd2;
   localparam logic [BPP_W-1:0] BPP_3 = 3'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_RED_OFFSET      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RED_LENGTH      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GREEN_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_OFFSET     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_BLUE_LENGTH     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FADE_OUT        = 3'd7;

   typedef struct packed {
      logic [OFFSET_W-1:0] red_offset;
      logic [LENGTH_W-1:0] red_length;
      logic [OFFSET_W-1:0] green_offset;
      logic [LENGTH_W-1:0] green_length;
      logic [OFFSET_W-1:0] blue_offset;
      logic [LENGTH_W-1:0] blue_length;
      logic [BPP_W-1:0]    bytes_per_pixel;
      logic                fade_out;
   } cfg_type;

endpackage

`default_nettype wire

// ----- hdl/rpfs_csr.sv -----
// ----------------------------------------------------------------------------
// RGB pixel fade scaler configuration registers
// Holds the channel layout, pixel size and fade direction.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfs_csr
   import rpfs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_RED_OFFSET:      cfg_in.red_offset      = wr_data[OFFSET_W-1:0];
            REG_RED_LENGTH:      cfg_in.red_length      = wr_data[LENGTH_W-1:0];
            REG_GREEN_OFFSET:    cfg_in.green_offset    = wr_data[OFFSET_W-1:0];
            REG_GREEN_LENGTH:    cfg_in.green_length    = wr_data[LENGTH_W-1:0];
            REG_BLUE_OFFSET:     cfg_in.blue_offset     = wr_data[OFFSET_W-1:0];
            REG_BLUE_LENGTH:     cfg_in.blue_length     = wr_data[LENGTH_W-1:0];
            REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = wr_data[BPP_W-1:0];
            REG_FADE_OUT:        cfg_in.fade_out        = wr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_offset      <= 5'd16;
         cfg_ff.red_length      <= 4'd8;
         cfg_ff.green_offset    <= 5'd8;
         cfg_ff.green_length    <= 4'd8;
         cfg_ff.blue_offset     <= 5'd0;
         cfg_ff.blue_length     <= 4'd8;
         cfg_ff.bytes_per_pixel <= 3'd4;
         cfg_ff.fade_out        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/rpfs_chan.sv -----
// ----------------------------------------------------------------------------
// RGB pixel fade scaler channel
// Unpacks one color channel, scales it by the fade factor and repacks it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfs_chan
   import rpfs_pkg::*;
(
   input  wire logic [PIXEL_W-1:0]  word,
   input  wire logic [OFFSET_W-1:0] offset,
   input  wire logic [LENGTH_W-1:0] length,
   input  wire logic [FACTOR_W-1:0] factor,
   input  wire logic                narrow,
   output logic [PIXEL_W-1:0]       placed
);

   logic [LENGTH_W-1:0]        len_c;
   logic [LENGTH_W-1:0]        pad;
   logic [PIXEL_W-1:0]         field;
   logic [CHAN_W-1:0]          lmask;
   logic [CHAN_W-1:0]          wide;
   logic [FACTOR_W+CHAN_W-1:0] prod;
   logic [CHAN_W-1:0]          scaled;
   logic [CHAN_W-1:0]          narrowed;

   always_comb begin
      len_c    = (length > LENGTH_W'(CHAN_W)) ? LENGTH_W'(CHAN_W) : length;
      pad      = LENGTH_W'(CHAN_W) - len_c;
      field    = word >> offset;
      lmask    = CHAN_W'((9'd1 << len_c) - 9'd1);
      wide     = (field[CHAN_W-1:0] & lmask) << pad;
      prod     = (FACTOR_W+CHAN_W)'(factor) * (FACTOR_W+CHAN_W)'(wide);
      scaled   = CHAN_W'(prod / FADE_STEPS);
      narrowed = narrow ? (scaled >> pad) : scaled;
      placed   = PIXEL_W'(narrowed) << offset;
   end

endmodule

`default_nettype wire

// ----- hdl/rgb_pixel_fade_scaler.sv -----
// ----------------------------------------------------------------------------
// RGB pixel fade scaler
// Fades one framebuffer pixel per transaction by a step-dependent factor.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// req_     in         tdata[31:0] pixel_in, tdata[37:32] fade_step
// rsp_     out        tdata[31:0] pixel_out
// csr_     in         index selects the register, data holds its new value
//
// An accepted request enters the request register and its result the response
// register; one pixel is taken every cycle while the response is not stalled.
// Between them sit three channel units, one small multiplier each.
// Reset clears both valid flags and loads the default RGB888 layout.
// A stalled response holds the request register, which then holds req_tready low.
`default_nettype none
`include "rgb_pixel_fade_scaler_macros.svh"

module rgb_pixel_fade_scaler
   import rpfs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,  // pixel_in, fade_step, zero pad
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [PIXEL_W-1:0]          rsp_tdata,  // pixel_out
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [PIXEL_W-1:0]  pixel_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [PIXEL_W-1:0]  out_pixel_ff;
   logic [PIXEL_W-1:0]  out_pixel_in;

   logic                advance;
   logic [PIXEL_W-1:0]  pmask;
   logic                narrow;
   logic [PIXEL_W-1:0]  word;
   logic [STEP_W-1:0]   step_sat;
   logic [FACTOR_W-1:0] factor;
   logic [PIXEL_W-1:0]  red_placed;
   logic [PIXEL_W-1:0]  green_placed;
   logic [PIXEL_W-1:0]  blue_placed;

   assign csr_ready = 1'b1;

   rpfs_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      case (cfg.bytes_per_pixel)
         BPP_2: begin
            pmask  = MASK_16;
            narrow = 1'b1;
         end
         BPP_3: begin
            pmask  = MASK_24;
            narrow = 1'b0;
         end
         default: begin
            pmask  = MASK_32;
            narrow = 1'b0;
         end
      endcase
      word     = pixel_ff & pmask;
      step_sat = (int'(step_ff) > FADE_STEPS - 1) ? STEP_W'(FADE_STEPS - 1) : step_ff;
      if (cfg.fade_out) begin
         factor = FACTOR_W'(FADE_STEPS - 1) - FACTOR_W'(step_sat);
      end else begin
         factor = FACTOR_W'(step_sat) + FACTOR_W'(1);
      end
   end

   rpfs_chan u_red (
      .word   (word),
      .offset (cfg.red_offset),
      .length (cfg.red_length),
      .factor (factor),
      .narrow (narrow),
      .placed (red_placed)
   );

   rpfs_chan u_green (
      .word   (word),
      .offset (cfg.green_offset),
      .length (cfg.green_length),
      .factor (factor),
      .narrow (narrow),
      .placed (green_placed)
   );

   rpfs_chan u_blue (
      .word   (word),
      .offset (cfg.blue_offset),
      .length (cfg.blue_length),
      .factor (factor),
      .narrow (narrow),
      .placed (blue_placed)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_pixel_in = (red_placed | green_placed | blue_placed) & pmask;
      end
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pixel_ff <= req_tdata[PIXEL_W-1:0];
         step_ff  <= req_tdata[PIXEL_W+STEP_W-1:PIXEL_W];
      end
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pixel_ff;

   `RPFS_ASSERT_NEXT(a_req_loads, clock, reset, req_tvalid && req_tready, in_valid_ff)
   `RPFS_ASSERT_NEXT(a_in_holds, clock, reset, in_valid_ff && !advance,
                     in_valid_ff && $stable(pixel_ff) && $stable(step_ff))
   `RPFS_ASSERT_NEXT(a_in_moves, clock, reset, in_valid_ff && advance, rsp_tvalid)
   `RPFS_ASSERT_SAME(a_ready_rule, clock, reset, !req_tready, in_valid_ff && rsp_tvalid)

endmodule

`default_nettype wire
